// ----- src/srvf_pkg.sv -----
// Shared types and constants for the solvent radius visibility filter.
// Used by the distance pipeline and the top level; has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srvf_pkg;

    // Item opcodes carried in the low bits of the input tuser.
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Radius register and its square.
    localparam int RADIUS_BITS = 23;
    localparam int R2_BITS     = 2 * RADIUS_BITS;
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 23'd19200;
    localparam logic [R2_BITS-1:0]     R2_RESET     = 46'd368640000;

    // Control that travels alongside each table entry through the distance pipeline.
    typedef struct packed {
        logic valid;
        logic last;
    } srvf_tag_t;

endpackage

`default_nettype wire

// ----- src/srvf_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module srvf_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 4096
) (
    input  wire logic                                       clk,
    input  wire logic                                       wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                           wr_data,
    input  wire logic                                       rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/srvf_dist.sv -----
// Squared-distance pipeline: compares one stored reference position per cycle
// against the query position and the squared radius. Depends on srvf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srvf_dist #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire srvf_pkg::srvf_tag_t            issue_tag,
    input  wire logic [3*COORD_BITS-1:0]        ref_data,
    input  wire logic signed [COORD_BITS-1:0]   query_x,
    input  wire logic signed [COORD_BITS-1:0]   query_y,
    input  wire logic signed [COORD_BITS-1:0]   query_z,
    input  wire logic [srvf_pkg::R2_BITS-1:0]   r2,
    output srvf_pkg::srvf_tag_t                 res_tag,
    output logic                                res_hit
);

    import srvf_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int SQW  = 2 * CB;
    localparam int SUMW = SQW + 2;
    localparam int CMPW = SUMW > R2_BITS ? SUMW : R2_BITS;

    srvf_tag_t tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg;

    logic signed [CB:0] dx_reg, dy_reg, dz_reg;
    logic signed [CB:0] dx_next, dy_next, dz_next;
    logic signed [CB-1:0] ref_x, ref_y, ref_z;
    logic signed [2*CB+1:0] px, py, pz;
    logic [SQW-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic [SQW:0] sxy_reg, sxy_next;
    logic [SQW-1:0] sqz_d_reg;
    logic [SUMW-1:0] total;
    logic hit_reg, hit_next;

    // Tags follow the data: one stage for the RAM read, then four compute stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
            tag5_reg <= '0;
        end
        else
        begin
            tag1_reg <= issue_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
            tag5_reg <= tag4_reg;
        end
    end

    // Component differences, one bit wider than a coordinate.
    assign ref_x   = ref_data[CB-1:0];
    assign ref_y   = ref_data[2*CB-1:CB];
    assign ref_z   = ref_data[3*CB-1:2*CB];
    assign dx_next = {query_x[CB-1], query_x} - {ref_x[CB-1], ref_x};
    assign dy_next = {query_y[CB-1], query_y} - {ref_y[CB-1], ref_y};
    assign dz_next = {query_z[CB-1], query_z} - {ref_z[CB-1], ref_z};

    // Squares of the differences; the magnitude is below 2**CB, so the square fits SQW bits.
    assign px = dx_reg * dx_reg;
    assign py = dy_reg * dy_reg;
    assign pz = dz_reg * dz_reg;

    // Partial sum, then full sum against the squared radius.
    assign sxy_next = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign total    = SUMW'(sxy_reg) + SUMW'(sqz_d_reg);
    assign hit_next = CMPW'(total) <= CMPW'(r2);

    always_ff @(posedge clk)
    begin
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        dz_reg    <= dz_next;
        sqx_reg   <= px[SQW-1:0];
        sqy_reg   <= py[SQW-1:0];
        sqz_reg   <= pz[SQW-1:0];
        sxy_reg   <= sxy_next;
        sqz_d_reg <= sqz_reg;
        hit_reg   <= hit_next;
    end

    assign res_tag = tag5_reg;
    assign res_hit = hit_reg;

endmodule

`default_nettype wire

// ----- src/solvent_radius_visibility_filter_unit.sv -----
// Top level of the solvent radius visibility filter: control sequencer,
// reference table RAM and distance pipeline. Depends on srvf_pkg, srvf_ram, srvf_dist.
`timescale 1ns / 1ps
`default_nettype none

// The block holds up to MAX_REF_ATOMS reference positions in one RAM, one
// entry of three packed coordinates per address, and takes one transaction at
// a time. A clear, a load, an unused opcode, a non-solvent query or a solvent
// query against an empty table goes to the DONE state on acceptance and from there
// into the output register. A solvent query reads every stored entry through the
// single RAM read port, one entry per cycle, into a five-stage distance pipeline,
// then waits in DRAIN for the result of the last entry before it moves to DONE.
// The next transaction is accepted once the result has moved into the output
// register, which then waits for the downstream side on its own.
module solvent_radius_visibility_filter_unit #(
    parameter int MAX_REF_ATOMS = 4096,
    parameter int COORD_BITS    = 24
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        cfg_wr_en,
    input  wire logic [srvf_pkg::RADIUS_BITS-1:0]            cfg_wr_data,
    input  wire logic                                        s_tvalid,
    output logic                                             s_tready,
    // coord_x, coord_y, coord_z (COORD_BITS each), zero padding
    input  wire logic [((3*COORD_BITS+7)/8)*8-1:0]           s_tdata,
    // opcode [1:0], is_solvent [2]
    input  wire logic [2:0]                                  s_tuser,
    output logic                                             m_tvalid,
    input  wire logic                                        m_tready,
    // visible [0], zero padding
    output logic [7:0]                                       m_tdata,
    // status [0]
    output logic [0:0]                                       m_tuser
);

    import srvf_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int AW   = MAX_REF_ATOMS > 1 ? $clog2(MAX_REF_ATOMS) : 1;
    localparam int CNTW = $clog2(MAX_REF_ATOMS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic hit_acc_reg, hit_acc_next;
    logic res_vis_reg, res_vis_next;
    logic res_stat_reg, res_stat_next;
    logic out_valid_reg, out_valid_next;
    logic out_vis_reg, out_vis_next;
    logic out_stat_reg, out_stat_next;
    logic [RADIUS_BITS-1:0] radius_reg;
    logic [R2_BITS-1:0] r2_reg;
    logic signed [CB-1:0] qx_reg, qy_reg, qz_reg;

    logic accept;
    logic [1:0] opcode;
    logic is_solvent;
    logic signed [CB-1:0] coord_x, coord_y, coord_z;
    logic ram_we, ram_re;
    logic [3*CB-1:0] ram_rd_data;
    logic scan_last;
    srvf_tag_t issue_tag, res_tag;
    logic res_hit;

    // Input field unpacking.
    assign opcode     = s_tuser[1:0];
    assign is_solvent = s_tuser[2];
    assign coord_x    = s_tdata[CB-1:0];
    assign coord_y    = s_tdata[2*CB-1:CB];
    assign coord_z    = s_tdata[3*CB-1:2*CB];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign scan_last = (CNTW'(addr_reg) + CNTW'(1)) == count_reg;

    // Radius register and its square; the square is registered from the radius and follows a write in the next cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            r2_reg     <= R2_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                radius_reg <= cfg_wr_data;
            end
            r2_reg <= R2_BITS'(radius_reg) * R2_BITS'(radius_reg);
        end
    end

    // Sequencer. Writes happen only in IDLE and reads only in SCAN, so a table
    // entry is never read and written in overlapping cycles.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        hit_acc_next   = hit_acc_reg;
        res_vis_next   = res_vis_reg;
        res_stat_next  = res_stat_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_vis_next   = out_vis_reg;
        out_stat_next  = out_stat_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        issue_tag      = '0;

        if (res_tag.valid && res_hit)
        begin
            hit_acc_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    hit_acc_next  = 1'b0;
                    res_vis_next  = 1'b0;
                    res_stat_next = 1'b0;
                    addr_next     = '0;
                    state_next    = ST_DONE;
                    unique case (opcode)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_LOAD:
                        begin
                            if (count_reg == CNTW'(MAX_REF_ATOMS))
                            begin
                                res_stat_next = 1'b1;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CNTW'(1);
                            end
                        end
                        OP_QUERY:
                        begin
                            if (!is_solvent)
                            begin
                                res_vis_next = 1'b1;
                            end
                            else if (count_reg != '0)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                ram_re          = 1'b1;
                issue_tag.valid = 1'b1;
                issue_tag.last  = scan_last;
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (res_tag.valid && res_tag.last)
                begin
                    res_vis_next = hit_acc_reg || res_hit;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_vis_next   = res_vis_reg;
                    out_stat_next  = res_stat_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            addr_reg      <= '0;
            hit_acc_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            addr_reg      <= addr_next;
            hit_acc_reg   <= hit_acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: query position and results.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qx_reg <= coord_x;
            qy_reg <= coord_y;
            qz_reg <= coord_z;
        end
        res_vis_reg  <= res_vis_next;
        res_stat_reg <= res_stat_next;
        out_vis_reg  <= out_vis_next;
        out_stat_reg <= out_stat_next;
    end

    // Reference table, one entry of {z, y, x} per address.
    srvf_ram #(
        .WIDTH (3 * CB),
        .DEPTH (MAX_REF_ATOMS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({coord_z, coord_y, coord_x}),
        .rd_en   (ram_re),
        .rd_addr (addr_reg),
        .rd_data (ram_rd_data)
    );

    // Distance pipeline.
    srvf_dist #(
        .COORD_BITS (CB)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue_tag (issue_tag),
        .ref_data  (ram_rd_data),
        .query_x   (qx_reg),
        .query_y   (qy_reg),
        .query_z   (qz_reg),
        .r2        (r2_reg),
        .res_tag   (res_tag),
        .res_hit   (res_hit)
    );

    // Output register.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_vis_reg};
    assign m_tuser  = out_stat_reg;

endmodule

`default_nettype wire

// ----- tb/solvent_radius_visibility_filter_unit_tb.sv -----
// Self-checking testbench for the solvent radius visibility filter unit.
// Depends on srvf_pkg and the RTL under src; it needs no other files.
`timescale 1ns / 1ps

module solvent_radius_visibility_filter_unit_tb;

    import srvf_pkg::*;

    localparam int TABLE_DEPTH = 4096;
    localparam int COORD_W     = 24;
    localparam int LIMIT       = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYC  = 16;
    localparam int SCAN_LOADS  = 20;

    // Opcode 3 has no meaning in the block and must act as a no-op.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic visible;
        logic status;
    } filt_result_t;

    // Block ports; every input starts at a known value.
    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    cfg_wr_en   = 1'b0;
    logic [RADIUS_BITS-1:0]  cfg_wr_data = '0;
    logic                    s_tvalid    = 1'b0;
    logic                    s_tready;
    logic [3*COORD_W-1:0]    s_tdata     = '0;
    logic [2:0]              s_tuser     = '0;
    logic                    m_tvalid;
    logic                    m_tready    = 1'b0;
    logic [7:0]              m_tdata;
    logic [0:0]              m_tuser;

    // Predicted block state.
    coord_t                  tbl_x [TABLE_DEPTH];
    coord_t                  tbl_y [TABLE_DEPTH];
    coord_t                  tbl_z [TABLE_DEPTH];
    int                      tbl_count = 0;
    logic [RADIUS_BITS-1:0]  radius_q  = RADIUS_RESET;

    filt_result_t            expected_q [$];

    bit                      src_idle_en  = 1'b1;
    bit                      snk_idle_en  = 1'b1;
    bit                      hold_pending = 1'b0;
    int                      cycle_cnt    = 0;
    int                      n_fail       = 0;
    int                      n_sent       = 0;
    int                      n_results    = 0;
    int                      n_visible    = 0;

    solvent_radius_visibility_filter_unit #(
        .MAX_REF_ATOMS(TABLE_DEPTH),
        .COORD_BITS   (COORD_W)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    always #4 clk = ~clk;

    // Applies one item to the predicted table and returns the answer it should give.
    function automatic filt_result_t apply_item(input logic [1:0] op, input logic sol,
                                                input coord_t x, input coord_t y,
                                                input coord_t z);
        filt_result_t res;
        longint       r2;
        longint       dx;
        longint       dy;
        longint       dz;
        res = '0;
        case (op)
            OP_CLEAR: tbl_count = 0;
            OP_LOAD:
            begin
                if (tbl_count >= TABLE_DEPTH)
                begin
                    res.status = 1'b1;
                end
                else
                begin
                    tbl_x[tbl_count] = x;
                    tbl_y[tbl_count] = y;
                    tbl_z[tbl_count] = z;
                    tbl_count++;
                end
            end
            OP_QUERY:
            begin
                if (!sol)
                begin
                    res.visible = 1'b1;
                end
                else
                begin
                    r2 = longint'(radius_q) * longint'(radius_q);
                    for (int k = 0; k < tbl_count; k++)
                    begin
                        dx = longint'(x) - longint'(tbl_x[k]);
                        dy = longint'(y) - longint'(tbl_y[k]);
                        dz = longint'(z) - longint'(tbl_z[k]);
                        if (dx * dx + dy * dy + dz * dz <= r2)
                        begin
                            res.visible = 1'b1;
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic coord_t rand_coord();
        return coord_t'($urandom);
    endfunction

    // A coordinate uniformly within span of base; it wraps like the 24-bit field does.
    function automatic coord_t near(input coord_t base, input int span);
        return coord_t'(int'(base) + int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // Offset from a stored reference: exact hit, well inside, around or just past the radius.
    function automatic coord_t jitter(input coord_t base, input int span);
        case ($urandom_range(0, 3))
            0: return base;
            1: return near(base, span / 2);
            2: return near(base, span);
            default: return near(base, span + 2);
        endcase
    endfunction

    // Offers one transaction, waits for acceptance and records the expected answer.
    task automatic send_item(input logic [1:0] op, input logic sol,
                             input coord_t x, input coord_t y, input coord_t z);
        while (src_idle_en && $urandom_range(0, 99) < 32)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        s_tuser  <= {sol, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_q.push_back(apply_item(op, sol, x, y, z));
        n_sent++;
    endtask

    // Stops offering and waits until every expected answer has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_radius(input logic [RADIUS_BITS-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        radius_q     = value;
    endtask

    // Empty table, non-solvent and unused opcodes, then exact boundaries at the reset radius.
    task automatic test_basic_ops();
        send_item(OP_QUERY, 1'b1, 0, 0, 0);
        send_item(OP_QUERY, 1'b0, -8388608, 8388607, -1);
        send_item(OP_UNUSED, 1'b1, -1, -1, -1);
        send_item(OP_CLEAR, 1'b1, rand_coord(), rand_coord(), rand_coord());
        send_item(OP_LOAD, 1'b1, 0, 0, 0);
        send_item(OP_QUERY, 1'b1, 19200, 0, 0);
        send_item(OP_QUERY, 1'b1, 0, -19201, 0);
        send_item(OP_QUERY, 1'b1, 11520, 15360, 0);
        send_item(OP_QUERY, 1'b1, 6400, 12800, 12800);
        send_item(OP_QUERY, 1'b1, 6400, 12800, 12801);
        send_item(OP_QUERY, 1'b1, -6400, -12800, -12800);
        send_item(OP_LOAD, 1'b0, -8388608, 8388607, -8388608);
        send_item(OP_QUERY, 1'b1, 8388607, -8388608, 8388607);
        send_item(OP_QUERY, 1'b1, -8388608, 8388607, -8388608);
        send_item(OP_QUERY, 1'b0, 8388607, 8388607, 8388607);
    endtask

    // Zero radius needs an exact hit; the largest radius must not overflow the distance sum.
    task automatic test_radius_extremes();
        write_radius('0);
        send_item(OP_CLEAR, 1'b0, 0, 0, 0);
        send_item(OP_LOAD, 1'b0, 100, -200, 300);
        send_item(OP_QUERY, 1'b1, 100, -200, 300);
        send_item(OP_QUERY, 1'b1, 101, -200, 300);
        write_radius({RADIUS_BITS{1'b1}});
        send_item(OP_CLEAR, 1'b0, 0, 0, 0);
        send_item(OP_LOAD, 1'b0, -8388608, 0, 0);
        send_item(OP_QUERY, 1'b1, -1, 0, 0);
        send_item(OP_QUERY, 1'b1, 0, 0, 0);
        send_item(OP_QUERY, 1'b1, 8388607, 8388607, 8388607);
        send_item(OP_LOAD, 1'b0, 0, 0, 0);
        send_item(OP_QUERY, 1'b1, 4194304, 4194304, 4194304);
        send_item(OP_QUERY, 1'b1, 5000000, 5000000, 5000000);
    endtask

    // Loads a longer run of references and checks hits on the first and the last entry.
    task automatic test_long_scan();
        coord_t hx;
        src_idle_en = 1'b0;
        snk_idle_en = 1'b1;
        write_radius(23'd64);
        send_item(OP_CLEAR, 1'b0, 0, 0, 0);
        for (int k = 0; k < SCAN_LOADS; k++)
            send_item(OP_LOAD, 1'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                      rand_coord());
        send_item(OP_QUERY, 1'b1, 1000, 2000, 3000);
        send_item(OP_QUERY, 1'b1, tbl_x[SCAN_LOADS-1], tbl_y[SCAN_LOADS-1],
                  tbl_z[SCAN_LOADS-1]);
        hx = coord_t'(int'(tbl_x[0]) + 64);
        send_item(OP_QUERY, 1'b1, hx, tbl_y[0], tbl_z[0]);
        hx = coord_t'(int'(tbl_x[0]) + 65);
        send_item(OP_QUERY, 1'b1, hx, tbl_y[0], tbl_z[0]);
        send_item(OP_QUERY, 1'b0, 0, 0, 0);
        send_item(OP_CLEAR, 1'b0, 0, 0, 0);
        send_item(OP_QUERY, 1'b1, tbl_x[0], tbl_y[0], tbl_z[0]);
        src_idle_en = 1'b1;
    endtask

    // The sink stops for a long stretch while items keep coming, so the input stalls.
    task automatic test_output_stall();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b1;
        write_radius(23'd512);
        send_item(OP_CLEAR, 1'b0, 0, 0, 0);
        hold_pending = 1'b1;
        repeat (12)
        begin
            send_item(OP_LOAD, 1'b0, near(0, 2000), near(0, 2000), near(0, 2000));
            send_item(OP_QUERY, 1'b1, near(0, 2000), near(0, 2000), near(0, 2000));
        end
        src_idle_en = 1'b1;
    endtask

    // Clustered loads and queries around one center at a given radius, with some noise.
    task automatic test_random_phase(input int n_items, input logic [RADIUS_BITS-1:0] rad,
                                     input bit with_idle);
        coord_t hub;
        coord_t qx;
        coord_t qy;
        coord_t qz;
        int     pick;
        int     span;
        int     k;
        write_radius(rad);
        src_idle_en = with_idle;
        snk_idle_en = with_idle;
        hub  = rand_coord();
        span = int'(rad);
        send_item(OP_CLEAR, 1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord());
        repeat (n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                send_item(OP_LOAD, 1'($urandom_range(0, 1)), near(hub, 2 * span + 8),
                          near(hub, 2 * span + 8), near(hub, 2 * span + 8));
            end
            else if (pick < 85)
            begin
                if (tbl_count > 0 && $urandom_range(0, 9) < 7)
                begin
                    k  = $urandom_range(0, tbl_count - 1);
                    qx = jitter(tbl_x[k], span);
                    qy = jitter(tbl_y[k], span);
                    qz = jitter(tbl_z[k], span);
                end
                else
                begin
                    qx = near(hub, 2 * span + 8);
                    qy = near(hub, 2 * span + 8);
                    qz = near(hub, 2 * span + 8);
                end
                send_item(OP_QUERY, 1'($urandom_range(0, 99) < 85), qx, qy, qz);
            end
            else if (pick < 93)
            begin
                send_item(2'($urandom), 1'($urandom), rand_coord(), rand_coord(),
                          rand_coord());
            end
            else if (pick < 97)
            begin
                send_item(OP_UNUSED, 1'($urandom), rand_coord(), rand_coord(), rand_coord());
            end
            else
            begin
                send_item(OP_CLEAR, 1'($urandom), rand_coord(), rand_coord(), rand_coord());
            end
        end
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
    endtask

    // Result sink: random stalls, plus one long hold-off counted here when requested.
    initial
    begin : result_sink
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= !snk_idle_en || ($urandom_range(0, 99) >= 32);
        end
    end

    // Compare every accepted result with the oldest pending expectation.
    always @(posedge clk)
    begin
        filt_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("Result with nothing pending: visible %0b status %0b",
                       m_tdata[0], m_tuser[0]);
                n_fail++;
            end
            else
            begin
                want = expected_q.pop_front();
                n_results++;
                if (want.visible)
                    n_visible++;
                if (m_tdata[0] !== want.visible)
                begin
                    $error("visible: expected %0b, actual %0b", want.visible, m_tdata[0]);
                    n_fail++;
                end
                if (m_tuser[0] !== want.status)
                begin
                    $error("status: expected %0b, actual %0b", want.status, m_tuser[0]);
                    n_fail++;
                end
            end
        end
    end

    // Cycle counter; ends a run that hangs.
    initial
    begin : watchdog
        while (cycle_cnt < LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("solvent_radius_visibility_filter_unit_tb failed");
        $finish;
    end

    // Test sequence.
    initial
    begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_radius_extremes();
        test_long_scan();
        test_output_stall();
        test_random_phase(12, RADIUS_RESET, 1'b1);
        test_random_phase(12, RADIUS_BITS'($urandom_range(0, 8388607)), 1'b0);
        test_random_phase(8, '0, 1'b1);
        test_random_phase(12, RADIUS_BITS'($urandom_range(1, 400)), 1'b1);
        test_random_phase(8, {RADIUS_BITS{1'b1}}, 1'b1);

        settle();
        repeat (SETTLE_CYC) @(posedge clk);
        if (expected_q.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_q.size());
            n_fail++;
        end

        $display("Run covered %0d transactions in %0d cycles: boundary queries, radius",
                 n_sent, cycle_cnt);
        $display("extremes, a longer table scan and a long output stall; %0d were visible.",
                 n_visible);
        if (n_fail == 0)
            $display("solvent_radius_visibility_filter_unit_tb passed");
        else
            $display("solvent_radius_visibility_filter_unit_tb failed");
        $finish;
    end

endmodule

// ----- files.f -----
src/srvf_pkg.sv
src/srvf_ram.sv
src/srvf_dist.sv
src/solvent_radius_visibility_filter_unit.sv
tb/solvent_radius_visibility_filter_unit_tb.sv
